// File: hdl/mssc_pkg.sv
// shared types, opcodes and sizes for the mips subset step core
// used by every module under hdl; depends on nothing
package mssc_pkg;

   // data memory size in words and derived widths
   localparam int DATA_WORDS = 1024;
   localparam int DADDR_W    = $clog2(DATA_WORDS);
   localparam int CLR_W      = DADDR_W + 1;
   localparam logic [31:0] WINDOW_BYTES = 32'(4 * DATA_WORDS);

   // reset values of the configuration registers and the jump region mask
   localparam logic [31:0] TEXT_START_RESET = 32'h0040_0000;
   localparam logic [31:0] DATA_START_RESET = 32'h1000_0000;
   localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INSTR_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START = 2'd2;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // function codes of the special opcode
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   localparam logic [4:0] REG_RA = 5'd31;

   // result item, last field in the lowest bits
   localparam int RSP_W = 144;
   typedef struct packed {
      logic [5:0]  pad;
      logic        address_out_of_range;
      logic        unknown_instruction;
      logic [31:0] mem_data;
      logic [31:0] mem_address;
      logic        mem_write_enable;
      logic [31:0] reg_value;
      logic [4:0]  reg_index;
      logic        reg_write_enable;
      logic        running;
      logic [31:0] next_pc;
   } rsp_type;

   // execute stage result: the item plus memory control
   typedef struct packed {
      rsp_type             rsp;
      logic                is_load;
      logic                mem_hit;
      logic [DADDR_W-1:0]  mem_idx;
   } exec_out_type;

endpackage

// File: hdl/mips_subset_instruction_step_core.sv
// mips subset step core: top level with handshakes, pc, operand forwarding
// and result register; uses mssc_pkg, mssc_regfile, mssc_dmem, mssc_exec
//
// usage: each item on req_ is the instruction word at the current pc. the
// core executes it and returns one item on rsp_ with next pc, register and
// memory effects and status flags. csr_ writes text_start (0),
// instruction_count (1) and data_start (2); the user writes them only while
// the core is idle, which the core itself does not enforce. the register
// file is read at accept; a non-load item goes from execute to the result
// register, a load from execute through write-back (the data memory read).
// throughput: one item per cycle for non-loads while the output is not
// stalled; no new item is taken while a lw is in execute.
// reset: pc, config and register file return to reset values; the data
// memory is then swept to zero, one word a cycle over all DATA_WORDS (1024)
// words, during which req_tready stays low. csr writes are taken always.
// stall: the result register holds while rsp_tready is low; an item in
// flight waits behind it and req_tready drops until it can move on.
module mips_subset_instruction_step_core (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: instruction_word[31:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,
   // rsp_tdata: next_pc[31:0], running[32], reg_write_enable[33],
   // reg_index[38:34], reg_value[70:39], mem_write_enable[71],
   // mem_address[103:72], mem_data[135:104], unknown_instruction[136],
   // address_out_of_range[137], zero fill[143:138]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mssc_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);
   import mssc_pkg::*;

   // configuration registers
   logic [31:0] text_start_ff;
   logic [29:0] instr_count_ff;
   logic [31:0] data_start_ff;

   // pipeline control
   logic        ex_valid_ff;
   logic        ex_valid_in;
   logic        wb_valid_ff;
   logic        wb_valid_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] pc_ff;

   // payload
   logic [31:0] ex_instr_ff;
   logic [31:0] ex_sdiff_ff;
   rsp_type     wb_rsp_ff;
   logic        wb_hit_ff;
   rsp_type     rsp_ff;
   rsp_type     wb_rsp;

   // forwarding of the most recent register write
   logic        fwd_valid_ff;
   logic [4:0]  fwd_idx_ff;
   logic [31:0] fwd_val_ff;

   logic        accept;
   logic        out_free;
   logic        ex_fire;
   logic        ex_to_wb;
   logic        wb_fire;
   logic        clr_busy;
   logic [31:0] rf_a;
   logic [31:0] rf_b;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] dmem_rdata;
   logic [31:0] load_val;
   logic        rf_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rf_wdata;
   logic        dmem_en;
   logic [31:0] req_simm;
   exec_out_type xo;

   // handshake and stage movement
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ex_fire    = ex_valid_ff && !xo.is_load && out_free;
   assign ex_to_wb   = ex_valid_ff && xo.is_load;
   assign wb_fire    = wb_valid_ff && out_free;
   assign req_tready = !clr_busy && ((!ex_valid_ff && !wb_valid_ff) || ex_fire || wb_fire);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ex_valid_in  = accept ? 1'b1 : ((ex_fire || ex_to_wb) ? 1'b0 : ex_valid_ff);
   assign wb_valid_in  = ex_to_wb ? 1'b1 : (wb_fire ? 1'b0 : wb_valid_ff);
   assign rsp_valid_in = (ex_fire || wb_fire) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // register file
   mssc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_tdata[25:21]),
      .rd_addr_b (req_tdata[20:16]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr_en     (rf_we),
      .wr_addr   (rf_waddr),
      .wr_data   (rf_wdata)
   );

   // operands with bypass of a write that landed at the read edge
   assign op_a = (fwd_valid_ff && fwd_idx_ff == ex_instr_ff[25:21]) ? fwd_val_ff : rf_a;
   assign op_b = (fwd_valid_ff && fwd_idx_ff == ex_instr_ff[20:16]) ? fwd_val_ff : rf_b;

   mssc_exec u_exec (
      .instr       (ex_instr_ff),
      .op_a        (op_a),
      .op_b        (op_b),
      .pc          (pc_ff),
      .sdiff       (ex_sdiff_ff),
      .text_start  (text_start_ff),
      .instr_count (instr_count_ff),
      .xo          (xo)
   );

   // data memory: store at execute, load read issued when moving to write-back
   assign dmem_en = xo.mem_hit && (ex_to_wb || (ex_fire && xo.rsp.mem_write_enable));

   mssc_dmem u_dmem (
      .clock    (clock),
      .reset    (reset),
      .en       (dmem_en),
      .we       (!xo.is_load),
      .addr     (xo.mem_idx),
      .wdata    (op_b),
      .rdata    (dmem_rdata),
      .clr_busy (clr_busy)
   );

   // load completion
   assign load_val = wb_hit_ff ? dmem_rdata : 32'd0;
   always_comb begin
      wb_rsp           = wb_rsp_ff;
      wb_rsp.mem_data  = load_val;
      wb_rsp.reg_value = wb_rsp_ff.reg_write_enable ? load_val : 32'd0;
   end

   // register write-back
   assign rf_we    = (ex_fire && xo.rsp.reg_write_enable) ||
                     (wb_fire && wb_rsp_ff.reg_write_enable);
   assign rf_waddr = wb_fire ? wb_rsp_ff.reg_index : xo.rsp.reg_index;
   assign rf_wdata = wb_fire ? wb_rsp.reg_value : xo.rsp.reg_value;

   assign req_simm = {{16{req_tdata[15]}}, req_tdata[15:0]};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         text_start_ff  <= TEXT_START_RESET;
         instr_count_ff <= '0;
         data_start_ff  <= DATA_START_RESET;
         pc_ff          <= TEXT_START_RESET;
         ex_valid_ff    <= 1'b0;
         wb_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         fwd_idx_ff     <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire || ex_to_wb) begin
            pc_ff <= xo.rsp.next_pc;
         end
         if (rf_we) begin
            fwd_valid_ff <= 1'b1;
            fwd_idx_ff   <= rf_waddr;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEXT_START:  text_start_ff  <= csr_data;
               CSR_INSTR_COUNT: instr_count_ff <= csr_data[29:0];
               CSR_DATA_START:  data_start_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_instr_ff <= req_tdata;
         ex_sdiff_ff <= req_simm - data_start_ff;
      end
      if (ex_to_wb) begin
         wb_rsp_ff <= xo.rsp;
         wb_hit_ff <= xo.mem_hit;
      end
      if (rf_we) begin
         fwd_val_ff <= rf_wdata;
      end
      if (ex_fire) begin
         rsp_ff <= xo.rsp;
      end else if (wb_fire) begin
         rsp_ff <= wb_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// File: hdl/mssc_regfile.sv
// 32 x 32 general register file, two registered read ports, one write port
// entries read as zero until first written; uses mssc_pkg
module mssc_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   import mssc_pkg::*;

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;
   logic        valid_a_ff;
   logic        valid_b_ff;

   // storage array, register 0 is never written
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != 5'd0) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   // written-since-reset flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (wr_en && wr_addr != 5'd0) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_a_ff <= valid_ff[rd_addr_a];
            valid_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = valid_a_ff ? data_a_ff : 32'd0;
   assign rd_data_b = valid_b_ff ? data_b_ff : 32'd0;

endmodule

// File: hdl/mssc_dmem.sv
// word-addressed data memory, single port, registered read data
// swept to zero after reset; uses mssc_pkg
module mssc_dmem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         we,
   input  logic [mssc_pkg::DADDR_W-1:0] addr,
   input  logic [31:0]                  wdata,
   output logic [31:0]                  rdata,
   output logic                         clr_busy
);
   import mssc_pkg::*;

   logic [31:0]      mem [DATA_WORDS];
   logic [31:0]      rdata_ff;
   logic [CLR_W-1:0] clr_cnt_ff;
   logic [CLR_W-1:0] clr_cnt_in;

   assign clr_busy   = clr_cnt_ff < CLR_W'(DATA_WORDS);
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // storage array, sweep writes zeros one word a cycle
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_cnt_ff[DADDR_W-1:0]] <= 32'd0;
      end else if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/mssc_exec.sv
// decode and execute of one instruction: alu, branch and jump targets,
// data window check and running flag; uses mssc_pkg
module mssc_exec (
   input  logic [31:0]          instr,
   input  logic [31:0]          op_a,
   input  logic [31:0]          op_b,
   input  logic [31:0]          pc,
   input  logic [31:0]          sdiff,
   input  logic [31:0]          text_start,
   input  logic [29:0]          instr_count,
   output mssc_pkg::exec_out_type xo
);
   import mssc_pkg::*;

   logic [5:0]  op;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [5:0]  fn;
   logic [15:0] imm;
   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] pc4;
   logic [31:0] br_target;
   logic [31:0] j_target;
   logic [32:0] text_end;
   logic [31:0] maddr;
   logic [31:0] moff;
   logic        hit;
   logic        wr;
   logic [4:0]  widx;
   logic [31:0] wval;
   logic [31:0] npc;
   logic        unk;
   logic        is_lw;
   logic        is_sw;

   // instruction fields
   assign op        = instr[31:26];
   assign rt        = instr[20:16];
   assign rd        = instr[15:11];
   assign sh        = instr[10:6];
   assign fn        = instr[5:0];
   assign imm       = instr[15:0];
   assign simm      = {{16{imm[15]}}, imm};
   assign zimm      = {16'd0, imm};

   // next pc candidates
   assign pc4       = pc + 32'd4;
   assign br_target = pc4 + {simm[29:0], 2'b00};
   assign j_target  = (pc4 & JUMP_REGION_MASK) | {4'd0, instr[25:0], 2'b00};
   assign text_end  = {1'b0, text_start} + {1'b0, instr_count, 2'b00};

   // data window: sdiff already holds simm minus data_start
   assign maddr = op_a + simm;
   assign moff  = op_a + sdiff;
   assign hit   = moff < WINDOW_BYTES;

   // operation decode
   always_comb begin
      wr    = 1'b0;
      widx  = rt;
      wval  = 32'd0;
      npc   = pc4;
      unk   = 1'b0;
      is_lw = 1'b0;
      is_sw = 1'b0;
      case (op)
         OP_SPECIAL: begin
            wr   = 1'b1;
            widx = rd;
            case (fn)
               FN_SLL:  wval = op_b << sh;
               FN_SRL:  wval = op_b >> sh;
               FN_ADDU: wval = op_a + op_b;
               FN_SUBU: wval = op_a - op_b;
               FN_AND:  wval = op_a & op_b;
               FN_OR:   wval = op_a | op_b;
               FN_NOR:  wval = ~(op_a | op_b);
               FN_SLTU: wval = {31'd0, op_a < op_b};
               FN_JR: begin
                  wr  = 1'b0;
                  npc = op_a;
               end
               default: begin
                  wr  = 1'b0;
                  unk = 1'b1;
               end
            endcase
         end
         OP_ADDIU: begin
            wr   = 1'b1;
            wval = op_a + simm;
         end
         OP_ANDI: begin
            wr   = 1'b1;
            wval = op_a & zimm;
         end
         OP_ORI: begin
            wr   = 1'b1;
            wval = op_a | zimm;
         end
         OP_SLTIU: begin
            wr   = 1'b1;
            wval = {31'd0, op_a < simm};
         end
         OP_LUI: begin
            wr   = 1'b1;
            wval = {imm, 16'd0};
         end
         OP_BEQ: begin
            if (op_a == op_b) npc = br_target;
         end
         OP_BNE: begin
            if (op_a != op_b) npc = br_target;
         end
         OP_J: begin
            npc = j_target;
         end
         OP_JAL: begin
            wr   = 1'b1;
            widx = REG_RA;
            wval = pc4;
            npc  = j_target;
         end
         OP_LW: begin
            wr    = 1'b1;
            is_lw = 1'b1;
         end
         OP_SW: begin
            is_sw = 1'b1;
         end
         default: begin
            unk = 1'b1;
         end
      endcase
   end

   // pack the item; a write to register zero is dropped
   always_comb begin
      xo                          = '0;
      xo.rsp.next_pc              = npc;
      xo.rsp.running              = {1'b0, pc4} < text_end;
      xo.rsp.reg_write_enable     = wr && (widx != 5'd0);
      xo.rsp.reg_index            = xo.rsp.reg_write_enable ? widx : 5'd0;
      xo.rsp.reg_value            = xo.rsp.reg_write_enable ? wval : 32'd0;
      xo.rsp.mem_write_enable     = is_sw && hit;
      xo.rsp.mem_address          = (is_lw || is_sw) ? maddr : 32'd0;
      xo.rsp.mem_data             = is_sw ? op_b : 32'd0;
      xo.rsp.unknown_instruction  = unk;
      xo.rsp.address_out_of_range = (is_lw || is_sw) && !hit;
      xo.is_load                  = is_lw;
      xo.mem_hit                  = (is_lw || is_sw) && hit;
      xo.mem_idx                  = moff[DADDR_W+1:2];
   end

endmodule

// File: verif/tb_mips_subset_instruction_step_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the mips subset step core: directed program, then random phases
// depends on mssc_pkg and mips_subset_instruction_step_core from hdl
module tb_mips_subset_instruction_step_core;
   import mssc_pkg::*;

   // codes outside the supported subset and the anchor registers of the random program
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [5:0] FN_UNUSED = 6'h3F;
   localparam logic [4:0] REG_WIN  = 5'd28;
   localparam logic [4:0] REG_HOME = 5'd29;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_data   = '0;

   // architectural state as the core should hold it
   logic [31:0] arch_pc = TEXT_START_RESET;
   logic [31:0] arch_regs [32] = '{default: '0};
   logic [31:0] arch_mem [DATA_WORDS] = '{default: '0};
   logic [31:0] cfg_text_start = TEXT_START_RESET;
   logic [29:0] cfg_instr_count = '0;
   logic [31:0] cfg_data_start = DATA_START_RESET;

   rsp_type pending_results [$];
   int      failures = 0;
   int      send_idle_pct = 0;
   int      rcv_stall_pct = 0;

   typedef struct {
      logic [31:0] word;
      bit          typed;
      rsp_type     want;
   } program_row_type;

   program_row_type boot_program [$];

   mips_subset_instruction_step_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // instruction encoders
   function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   // executes one instruction on the architectural state and returns its result item
   function automatic rsp_type execute_instruction(input logic [31:0] w);
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh, widx;
      logic [31:0] imm, simm, a, b, pc4, npc, wval, maddr, offs;
      logic [32:0] text_end;
      logic        wr, hit;
      rsp_type     r;
      op   = w[31:26];
      rs   = w[25:21];
      rt   = w[20:16];
      rd   = w[15:11];
      sh   = w[10:6];
      fn   = w[5:0];
      imm  = {16'h0000, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a    = arch_regs[rs];
      b    = arch_regs[rt];
      pc4  = arch_pc + 32'd4;
      npc  = pc4;
      r    = '0;
      wr   = 1'b0;
      widx = '0;
      wval = '0;
      // data window lookup, offset wraps
      maddr = a + simm;
      offs  = maddr - cfg_data_start;
      hit   = offs < WINDOW_BYTES;
      if (op == OP_SPECIAL) begin
         wr   = 1'b1;
         widx = rd;
         case (fn)
            FN_SLL:  wval = b << sh;
            FN_SRL:  wval = b >> sh;
            FN_ADDU: wval = a + b;
            FN_SUBU: wval = a - b;
            FN_AND:  wval = a & b;
            FN_OR:   wval = a | b;
            FN_NOR:  wval = ~(a | b);
            FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
            FN_JR: begin
               wr  = 1'b0;
               npc = a;
            end
            default: begin
               wr = 1'b0;
               r.unknown_instruction = 1'b1;
            end
         endcase
      end else begin
         case (op)
            OP_ADDIU: begin wr = 1'b1; widx = rt; wval = a + simm; end
            OP_ANDI:  begin wr = 1'b1; widx = rt; wval = a & imm; end
            OP_ORI:   begin wr = 1'b1; widx = rt; wval = a | imm; end
            OP_SLTIU: begin wr = 1'b1; widx = rt; wval = (a < simm) ? 32'd1 : 32'd0; end
            OP_LUI:   begin wr = 1'b1; widx = rt; wval = imm << 16; end
            OP_BEQ: begin
               if (a == b) npc = pc4 + (simm << 2);
            end
            OP_BNE: begin
               if (a != b) npc = pc4 + (simm << 2);
            end
            OP_J: npc = (pc4 & JUMP_REGION_MASK) | {4'h0, w[25:0], 2'b00};
            OP_JAL: begin
               wr   = 1'b1;
               widx = REG_RA;
               wval = pc4;
               npc  = (pc4 & JUMP_REGION_MASK) | {4'h0, w[25:0], 2'b00};
            end
            OP_LW: begin
               r.mem_address = maddr;
               if (hit) r.mem_data = arch_mem[offs[DADDR_W+1:2]];
               else r.address_out_of_range = 1'b1;
               wr   = 1'b1;
               widx = rt;
               wval = r.mem_data;
            end
            OP_SW: begin
               r.mem_address = maddr;
               r.mem_data    = b;
               if (hit) begin
                  arch_mem[offs[DADDR_W+1:2]] = b;
                  r.mem_write_enable = 1'b1;
               end else begin
                  r.address_out_of_range = 1'b1;
               end
            end
            default: r.unknown_instruction = 1'b1;
         endcase
      end
      // writes to $0 vanish
      if (wr && widx != 5'd0) begin
         arch_regs[widx]    = wval;
         r.reg_write_enable = 1'b1;
         r.reg_index        = widx;
         r.reg_value        = wval;
      end
      arch_pc   = npc;
      r.next_pc = npc;
      // upper bound only, no wrap
      text_end  = {1'b0, cfg_text_start} + {1'b0, cfg_instr_count, 2'b00};
      r.running = {1'b0, pc4} < text_end;
      return r;
   endfunction

   // result right after reset: running is low since instruction_count is zero
   function automatic rsp_type reset_outcome(logic [31:0] npc, logic [4:0] idx,
                                             logic [31:0] val, logic [31:0] maddr,
                                             logic [31:0] mdata, logic mwe, logic unk,
                                             logic oor);
      rsp_type r;
      r = '0;
      r.next_pc              = npc;
      r.reg_write_enable     = (idx != 5'd0);
      r.reg_index            = idx;
      r.reg_value            = val;
      r.mem_address          = maddr;
      r.mem_data             = mdata;
      r.mem_write_enable     = mwe;
      r.unknown_instruction  = unk;
      r.address_out_of_range = oor;
      return r;
   endfunction

   task automatic add_step(input logic [31:0] word);
      boot_program.push_back('{word, 1'b0, '0});
   endtask

   task automatic add_known(input logic [31:0] word, input rsp_type want);
      boot_program.push_back('{word, 1'b1, want});
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $error("result item with no instruction outstanding, next_pc %h", got.next_pc);
         failures++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("running", want.running, got.running);
      compare_field("reg_write_enable", want.reg_write_enable, got.reg_write_enable);
      compare_field("reg_index", want.reg_index, got.reg_index);
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("mem_write_enable", want.mem_write_enable, got.mem_write_enable);
      compare_field("mem_address", want.mem_address, got.mem_address);
      compare_field("mem_data", want.mem_data, got.mem_data);
      compare_field("unknown_instruction", want.unknown_instruction,
                    got.unknown_instruction);
      compare_field("address_out_of_range", want.address_out_of_range,
                    got.address_out_of_range);
   endtask

   // result side: random backpressure, check at each accepted item
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_type'(rsp_tdata));
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // send one instruction item, predict its result on accept
   task automatic issue_instruction(input logic [31:0] word, input bit typed,
                                    input rsp_type want);
      rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predicted = execute_instruction(word);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // hold off the sender until every outstanding result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // write all registers, plus the unused index which the core must ignore
   task automatic program_config(input logic [31:0] ts, input logic [31:0] cnt,
                                 input logic [31:0] ds);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [31:0]          val [4];
      idx = '{CSR_TEXT_START, CSR_INSTR_COUNT, CSR_DATA_START, CSR_UNUSED};
      val = '{ts, cnt, ds, $urandom};
      foreach (idx[i]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_text_start  = ts;
      cfg_instr_count = cnt[29:0];
      cfg_data_start  = ds;
   endtask

   // one configuration setting followed by a random program
   task automatic run_phase(input logic [31:0] ts, input logic [31:0] cnt,
                            input logic [31:0] ds, input int send_pct, input int rcv_pct,
                            input int n_items);
      logic [5:0]  alu_fn [8] = '{FN_SLL, FN_SRL, FN_ADDU, FN_SUBU, FN_AND, FN_OR,
                                  FN_NOR, FN_SLTU};
      logic [5:0]  imm_op [5] = '{OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTIU, OP_LUI};
      logic [31:0] word;
      logic [25:0] target;
      logic [4:0]  dst, src, rt;
      logic [15:0] imm;
      int          sel;
      wait_for_results();
      program_config(ts, cnt, ds);
      send_idle_pct = send_pct;
      rcv_stall_pct = rcv_pct;
      // anchor the window base and the text start in registers
      issue_instruction(i_word(OP_LUI, 5'($urandom), REG_WIN, ds[31:16]), 1'b0, '0);
      issue_instruction(i_word(OP_ORI, REG_WIN, REG_WIN, ds[15:0]), 1'b0, '0);
      issue_instruction(i_word(OP_LUI, 5'($urandom), REG_HOME, ts[31:16]), 1'b0, '0);
      issue_instruction(i_word(OP_ORI, REG_HOME, REG_HOME, ts[15:0]), 1'b0, '0);
      repeat (n_items) begin
         if ($urandom_range(199) == 0) wait_for_results();
         sel = $urandom_range(99);
         dst = 5'($urandom_range(27));
         if ($urandom_range(7) == 0) dst = 5'($urandom_range(30, 31));
         src = 5'($urandom);
         rt  = ($urandom_range(3) == 0) ? src : 5'($urandom);
         imm = 16'($urandom);
         if (sel < 10) begin
            // noise, mostly unknown encodings
            word = $urandom;
         end else if (sel < 30) begin
            // loads and stores around the data window
            if ($urandom_range(7) != 0) imm = 16'(int'($urandom_range(4 * DATA_WORDS + 16)) - 8);
            if ($urandom_range(1)) word = i_word(OP_LW, REG_WIN, dst, imm);
            else word = i_word(OP_SW, REG_WIN, src, imm);
         end else if (sel < 55) begin
            word = r_word(alu_fn[$urandom_range(7)], src, rt, dst, 5'($urandom));
         end else if (sel < 80) begin
            word = i_word(imm_op[$urandom_range(4)], src, dst, imm);
         end else if (sel < 90) begin
            if ($urandom_range(3) != 0) imm = 16'(int'($urandom_range(16)) - 8);
            word = i_word($urandom_range(1) ? OP_BEQ : OP_BNE, src, rt, imm);
         end else if (sel < 96) begin
            target = $urandom_range(1) ? ts[27:2] : 26'($urandom);
            word = j_word($urandom_range(1) ? OP_J : OP_JAL, target);
         end else begin
            word = r_word(FN_JR, $urandom_range(1) ? REG_HOME : src, 5'($urandom),
                          5'($urandom), 5'($urandom));
         end
         issue_instruction(word, 1'b0, '0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed program from reset state
      add_known(r_word(FN_SLL, 5'd0, 5'd0, 5'd0, 5'd0),
                reset_outcome(32'h0040_0004, 5'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      add_known(32'hFFFF_FFFF,
                reset_outcome(32'h0040_0008, 5'd0, '0, '0, '0, 1'b0, 1'b1, 1'b0));
      add_known(i_word(OP_LUI, 5'd0, 5'd1, 16'hFFFF),
                reset_outcome(32'h0040_000C, 5'd1, 32'hFFFF_0000, '0, '0, 1'b0, 1'b0, 1'b0));
      add_known(i_word(OP_ORI, 5'd0, 5'd2, 16'hFFFF),
                reset_outcome(32'h0040_0010, 5'd2, 32'h0000_FFFF, '0, '0, 1'b0, 1'b0, 1'b0));
      add_known(i_word(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF),
                reset_outcome(32'h0040_0014, 5'd3, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, 1'b0));
      // address zero lies below the window: load returns zero, store is dropped
      add_known(i_word(OP_LW, 5'd0, 5'd4, 16'h0000),
                reset_outcome(32'h0040_0018, 5'd4, '0, '0, '0, 1'b0, 1'b0, 1'b1));
      add_known(i_word(OP_SW, 5'd0, 5'd3, 16'h0000),
                reset_outcome(32'h0040_001C, 5'd0, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
      add_known(j_word(OP_J, 26'h3FF_FFFF),
                reset_outcome(32'h0FFF_FFFC, 5'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      // window edges, low address bits ignored
      add_step(i_word(OP_LUI, 5'd0, 5'd5, 16'h1000));
      add_step(i_word(OP_SW, 5'd5, 5'd3, 16'h0FFC));
      add_step(i_word(OP_LW, 5'd5, 5'd6, 16'h0FFF));
      add_step(i_word(OP_SW, 5'd5, 5'd1, 16'h1000));
      // alu operations, unused fields set
      add_step(r_word(FN_ADDU, 5'd1, 5'd2, 5'd8, 5'd0));
      add_step(r_word(FN_SUBU, 5'd0, 5'd2, 5'd9, 5'd0));
      add_step(r_word(FN_AND, 5'd1, 5'd3, 5'd10, 5'd0));
      add_step(r_word(FN_OR, 5'd1, 5'd2, 5'd11, 5'd17));
      add_step(r_word(FN_NOR, 5'd0, 5'd0, 5'd12, 5'd0));
      add_step(r_word(FN_SLTU, 5'd2, 5'd1, 5'd13, 5'd0));
      add_step(i_word(OP_SLTIU, 5'd2, 5'd14, 16'hFFFF));
      add_step(r_word(FN_SLL, 5'd0, 5'd3, 5'd15, 5'd31));
      add_step(r_word(FN_SRL, 5'd0, 5'd3, 5'd16, 5'd31));
      add_step(i_word(OP_ANDI, 5'd3, 5'd17, 16'h8000));
      add_step(i_word(OP_ADDIU, 5'd3, 5'd0, 16'h0001));
      add_step(r_word(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd0));
      // control flow: branch to itself, taken and untaken bne, jal, jr to the top
      add_step(i_word(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
      add_step(i_word(OP_BNE, 5'd1, 5'd2, 16'h0002));
      add_step(i_word(OP_BNE, 5'd1, 5'd1, 16'h7FFF));
      add_step(j_word(OP_JAL, 26'h000_0000));
      add_step(i_word(OP_ADDIU, 5'd0, 5'd18, 16'hFFFC));
      add_step(r_word(FN_JR, 5'd18, 5'd31, 5'd31, 5'd31));
      // pc + 4 wraps to zero
      add_step(i_word(OP_BEQ, 5'd0, 5'd0, 16'h0000));

      send_idle_pct = 11;
      rcv_stall_pct = 64;
      foreach (boot_program[i])
         issue_instruction(boot_program[i].word, boot_program[i].typed, boot_program[i].want);

      // random phases: sender idles little, then receiver idles little, then no idling
      run_phase(32'h0040_0000, 32'd64, 32'h1000_0000, 11, 64, 264);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 11, 64, 264);
      run_phase(32'hFFFF_FFFC, 32'd0, 32'hFFFF_F000, 64, 11, 264);
      run_phase(32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 64, 11, 264);
      run_phase($urandom & 32'hFFFF_FFFC, $urandom_range(4096), $urandom & 32'hFFFF_FFFC,
                0, 0, 264);
      run_phase(32'h0040_0000, 32'd1000, 32'h1001_0000, 0, 0, 264);

      wait_for_results();
      repeat (16) @(posedge clock);
      if (failures == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
hdl/mssc_pkg.sv
hdl/mssc_regfile.sv
hdl/mssc_dmem.sv
hdl/mssc_exec.sv
hdl/mips_subset_instruction_step_core.sv
verif/tb_mips_subset_instruction_step_core.sv
